FILE: rtl/core/ste_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ste_pkg: shared types, codes and glyph tables
// Types passed between the front, the queue and the back of the segment
// text encoder, the glyph tables and the character classifier.
// ----------------------------------------------------------------------------
package ste_pkg;

    // display modes
    localparam logic [1:0] MODE_RAW   = 2'd0;
    localparam logic [1:0] MODE_SEG7  = 2'd1;
    localparam logic [1:0] MODE_SEG14 = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_GLYPH = 2'd1;
    localparam logic [1:0] ST_RAW      = 2'd2;

    // register indexes
    localparam logic [1:0] REG_SEG_MODE  = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT = 2'd1;
    localparam logic [1:0] REG_W_GLYPH   = 2'd2;

    // reset values of the registers
    localparam logic [1:0]  SEG_MODE_RST  = MODE_SEG7;
    localparam logic [8:0]  ROW_COUNT_RST = 9'd1;
    localparam logic [13:0] W_GLYPH_RST   = 14'd0;

    // character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UH    = 8'h48;
    localparam logic [7:0] CH_UL    = 8'h4C;
    localparam logic [7:0] CH_UP    = 8'h50;
    localparam logic [7:0] CH_UU    = 8'h55;
    localparam logic [7:0] CH_UY    = 8'h59;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LC    = 8'h63;
    localparam logic [7:0] CH_LF_   = 8'h66;
    localparam logic [7:0] CH_LH    = 8'h68;
    localparam logic [7:0] CH_LO    = 8'h6F;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    // letter index of W in the 14-segment alphabet
    localparam logic [4:0] ALPHA_W = 5'd22;

    // fixed driver bytes
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_PCT_0 = 8'h63;
    localparam logic [7:0] BYTE_PCT_1 = 8'h1D;
    localparam logic [7:0] BYTE_DP7   = 8'h80;

    localparam logic [7:0] HEX7 [16] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
        8'h7F, 8'h7B, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47
    };

    localparam logic [13:0] DIGIT14 [10] = '{
        14'h0C3F, 14'h0006, 14'h00DB, 14'h00CF, 14'h00E6,
        14'h00ED, 14'h00FD, 14'h1401, 14'h00FF, 14'h00EF
    };

    localparam logic [13:0] ALPHA14 [26] = '{
        14'h00F7, 14'h128F, 14'h0039, 14'h120F, 14'h00F9, 14'h0071, 14'h00BD,
        14'h00F6, 14'h1209, 14'h001F, 14'h2470, 14'h0038, 14'h0536, 14'h2136,
        14'h003F, 14'h00F3, 14'h203F, 14'h20F3, 14'h018D, 14'h1201, 14'h003E,
        14'h0C30, 14'h0000, 14'h2D00, 14'h1500, 14'h0C09
    };

    localparam logic [7:0] RING [8] = '{
        8'h08, 8'h10, 8'h02, 8'h80, 8'h40, 8'h20, 8'h01, 8'h04
    };

    // configuration as seen by the front and the back
    typedef struct packed {
        logic [1:0]  seg_mode;
        logic [8:0]  row_count;
        logic [13:0] w_glyph;
    } t_cfg;

    // results of one character: n bytes sharing valid flag and status
    typedef struct packed {
        logic [1:0] n;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       bv;
        logic [1:0] st;
        logic       nl;
    } t_job;

    // one queued item: job a always has results, job b may be empty
    typedef struct packed {
        t_job a;
        t_job b;
    } t_item;

    localparam t_job JOB_NONE = '0;

    // 7-segment glyph, zero when missing
    function automatic logic [7:0] glyph7(input logic [7:0] c);
        logic [7:0] g;
        g = 8'h00;
        priority if (c >= CH_0 && c <= CH_9) begin
            g = HEX7[4'(c - CH_0)];
        end else if (c >= CH_LA && c <= CH_LF_) begin
            g = HEX7[4'(c - CH_LA + 8'd10)];
        end else if (c >= CH_UA && c <= CH_UF) begin
            g = HEX7[4'(c - CH_UA + 8'd10)];
        end else if (c >= 8'd1 && c <= 8'd7) begin
            g = 8'h01 << c[2:0];
        end else begin
            unique case (c)
                CH_MINUS: g = 8'h01;
                CH_DQUOT: g = 8'h22;
                CH_HASH:  g = 8'h63;
                CH_APOS:  g = 8'h02;
                CH_LC:    g = 8'h0D;
                CH_LH:    g = 8'h17;
                CH_UH:    g = 8'h37;
                CH_UL:    g = 8'h0E;
                CH_LO:    g = 8'h35;
                CH_UP:    g = 8'h67;
                CH_UU:    g = 8'h7E;
                CH_LU:    g = 8'h1C;
                CH_UY:    g = 8'h33;
                default:  g = 8'h00;
            endcase
        end
        return g;
    endfunction

    // 14-segment glyph, zero when missing
    function automatic logic [13:0] glyph14(input logic [7:0] c, input logic [13:0] wg);
        logic [13:0] g;
        logic [4:0]  idx;
        g   = 14'h0000;
        idx = (c >= CH_LA) ? 5'(c - CH_LA) : 5'(c - CH_UA);
        priority if ((c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ)) begin
            g = (idx == ALPHA_W) ? wg : ALPHA14[idx];
        end else if (c >= CH_0 && c <= CH_9) begin
            g = DIGIT14[4'(c - CH_0)];
        end else if (c >= 8'd1 && c <= 8'd8) begin
            g = {RING[3'(c - 8'd1)], 6'b000000};
        end else begin
            unique case (c)
                CH_STAR:  g = 14'h3FC0;
                CH_SLASH: g = 14'h0C00;
                CH_PLUS:  g = 14'h12C0;
                CH_MINUS: g = 14'h00C0;
                CH_PCT:   g = 14'h2DE4;
                CH_HASH:  g = 14'h00E3;
                default:  g = 14'h0000;
            endcase
        end
        return g;
    endfunction

    // classify one character with its point flag into driver results
    function automatic t_job enc_char(input logic [7:0] c, input logic pt, input t_cfg cfg);
        t_job        j;
        logic [13:0] g14;
        logic [14:0] d;
        logic [7:0]  g7;
        j   = JOB_NONE;
        g14 = glyph14(c, cfg.w_glyph);
        d   = {pt, g14};
        g7  = glyph7(c);
        priority if (cfg.seg_mode != MODE_SEG7 && cfg.seg_mode != MODE_SEG14) begin
            j.n  = 2'd1;
            j.st = ST_RAW;
        end else if (c == CH_LF) begin
            j.n  = 2'd1;
            j.nl = 1'b1;
        end else if (c == CH_CR) begin
            j.n  = 2'd1;
            j.b0 = BYTE_CR;
            j.bv = 1'b1;
        end else if (cfg.seg_mode == MODE_SEG14) begin
            if (g14 != 14'h0000) begin
                j.n  = 2'd2;
                j.bv = 1'b1;
                j.b0 = d[7:0];
                j.b1 = {1'b0, d[14:8]};
            end else if (c == CH_SPACE) begin
                j.n  = 2'd2;
                j.bv = 1'b1;
                j.b1 = pt ? BYTE_DP7 : 8'h00;
            end
        end else if (c == CH_SPACE) begin
            j.n  = 2'd1;
            j.bv = 1'b1;
        end else if (c == CH_PCT) begin
            j.n  = 2'd2;
            j.bv = 1'b1;
            j.b0 = BYTE_PCT_0;
            j.b1 = BYTE_PCT_1;
        end else if (g7 == 8'h00) begin
            j.n  = 2'd1;
            j.st = ST_NO_GLYPH;
        end else begin
            j.n  = 2'd1;
            j.bv = 1'b1;
            j.b0 = g7 | (pt ? BYTE_DP7 : 8'h00);
        end
        return j;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ste_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ste_front: input side of the segment text encoder
// Holds one character back, folds a following point into it and turns each
// accepted item into at most two classified characters for the queue.
// ----------------------------------------------------------------------------
module ste_front
    import ste_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire  [7:0]  i_char_code,
    input  wire         i_end_of_text,
    input  wire  t_cfg  i_cfg,
    input  wire         i_q_full,
    output logic        o_in_stall,
    output logic        o_push,
    output t_item       o_item
);

    logic       r_held_valid;
    logic [7:0] r_held_char;
    logic       n_held_valid;
    logic [7:0] n_held_char;
    logic       in_fire;
    logic       is_pt;
    t_job       job_a;
    t_job       job_b;

    assign o_in_stall = i_q_full;
    assign in_fire    = i_in_valid && !i_q_full;
    assign is_pt      = (i_char_code == CH_DOT) || (i_char_code == CH_COLON);

    // held character update and the characters this item releases
    always_comb begin
        job_a        = JOB_NONE;
        job_b        = JOB_NONE;
        n_held_valid = r_held_valid;
        n_held_char  = r_held_char;
        if (r_held_valid) begin
            job_a = enc_char(r_held_char, is_pt, i_cfg);
            if (is_pt) begin
                n_held_valid = 1'b0;
            end else begin
                n_held_char = i_char_code;
            end
        end else begin
            n_held_char  = i_char_code;
            n_held_valid = 1'b1;
        end
        // end of text flushes whatever is still held
        if (i_end_of_text && n_held_valid) begin
            job_b        = enc_char(n_held_char, 1'b0, i_cfg);
            n_held_valid = 1'b0;
            n_held_char  = 8'h00;
        end
    end

    // pack so that the first job has results whenever either job has
    always_comb begin
        if (job_a.n == 2'd0) begin
            o_item.a = job_b;
            o_item.b = JOB_NONE;
        end else begin
            o_item.a = job_a;
            o_item.b = job_b;
        end
    end

    assign o_push = in_fire && (o_item.a.n != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_char  <= 8'h00;
        end else if (in_fire) begin
            r_held_valid <= n_held_valid;
            r_held_char  <= n_held_char;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/ste_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ste_queue: item queue between front and back
// Small FIFO of classified items; head is visible without a read cycle.
// ----------------------------------------------------------------------------
module ste_queue
    import ste_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    input  wire  t_item i_item,
    input  wire         i_pop,
    output logic        o_full,
    output logic        o_valid,
    output t_item       o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/ste_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ste_back: output side of the segment text encoder
// Walks the results of the queue head one per cycle when not stalled into the
// output register, keeps the cursor row and marks each item's last result.
// ----------------------------------------------------------------------------
module ste_back
    import ste_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire  t_cfg  i_cfg,
    input  wire         i_q_valid,
    input  wire  t_item i_head,
    output logic        o_pop,
    input  wire         i_out_stall,
    output logic        o_out_valid,
    output logic [7:0]  o_seg_byte,
    output logic        o_byte_valid,
    output logic [1:0]  o_status,
    output logic [7:0]  o_row_now,
    output logic        o_run_end
);

    logic       r_sel;
    logic       r_idx;
    logic [7:0] r_row;
    logic       r_out_valid;
    logic [7:0] r_seg_byte;
    logic       r_byte_valid;
    logic [1:0] r_status;
    logic [7:0] r_row_now;
    logic       r_run_end;

    t_job       cur;
    logic       last_in_job;
    logic       run_end;
    logic       load;
    logic [7:0] last_row;
    logic [7:0] nl_row;

    // current job and result position
    assign cur         = r_sel ? i_head.b : i_head.a;
    assign last_in_job = (cur.n == 2'd2) ? r_idx : 1'b1;
    assign run_end     = last_in_job && (r_sel || (i_head.b.n == 2'd0));
    assign load        = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_pop       = load && run_end;

    // last row, with zero rows read as one and more than 256 as 256
    always_comb begin
        priority if (i_cfg.row_count == 9'd0) begin
            last_row = 8'd0;
        end else if (i_cfg.row_count > 9'd256) begin
            last_row = 8'hFF;
        end else begin
            last_row = 8'(i_cfg.row_count - 9'd1);
        end
    end

    assign nl_row = (r_row >= last_row) ? last_row : r_row + 8'd1;

    // sequencing and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= 1'b0;
            r_idx       <= 1'b0;
            r_row       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                if (run_end) begin
                    r_sel <= 1'b0;
                    r_idx <= 1'b0;
                end else if (last_in_job) begin
                    r_sel <= 1'b1;
                    r_idx <= 1'b0;
                end else begin
                    r_idx <= 1'b1;
                end
                if (cur.nl) begin
                    r_row <= nl_row;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_seg_byte   <= r_idx ? cur.b1 : cur.b0;
            r_byte_valid <= cur.bv;
            r_status     <= cur.st;
            r_row_now    <= cur.nl ? nl_row : r_row;
            r_run_end    <= run_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_seg_byte   = r_seg_byte;
    assign o_byte_valid = r_byte_valid;
    assign o_status     = r_status;
    assign o_row_now    = r_row_now;
    assign o_run_end    = r_run_end;

endmodule
`default_nettype wire

FILE: rtl/core/segment_text_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_text_encoder: text to 7/14-segment driver bytes
// Character stream in, segment bytes out, with decimal-point folding,
// cursor row tracking and an APB register port.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_stall     i_char_code, i_end_of_text
//  output    out        o_out_valid / i_out_stall   o_seg_byte, o_byte_valid,
//                                                   o_status, o_row_now, o_run_end
//  config    in         psel, penable, pwrite       paddr, pwdata, prdata
//
//  The front takes one item per cycle while the queue has room.
//  The back emits one result per cycle while the output is not stalled; an
//  item carries 1 to 4 results, so that result count sets the rate.
//  The queue holds QDEPTH items; o_in_stall rises only when it is full.
//  Synchronous reset: nothing held, row 0, registers to their defaults.
// ----------------------------------------------------------------------------
module segment_text_encoder
    import ste_pkg::*;
#(
    parameter int QDEPTH = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_char_code,
    input  wire         i_end_of_text,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [7:0]  o_seg_byte,
    output logic        o_byte_valid,
    output logic [1:0]  o_status,
    output logic [7:0]  o_row_now,
    output logic        o_run_end,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]  r_seg_mode;
    logic [8:0]  r_row_count;
    logic [13:0] r_w_glyph;
    t_cfg        cfg;
    logic        cfg_wr;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_valid;
    t_item       q_item;
    t_item       q_head;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_mode  <= SEG_MODE_RST;
            r_row_count <= ROW_COUNT_RST;
            r_w_glyph   <= W_GLYPH_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SEG_MODE:  r_seg_mode  <= pwdata[1:0];
                REG_ROW_COUNT: r_row_count <= pwdata[8:0];
                REG_W_GLYPH:   r_w_glyph   <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SEG_MODE:  prdata = 32'(r_seg_mode);
            REG_ROW_COUNT: prdata = 32'(r_row_count);
            REG_W_GLYPH:   prdata = 32'(r_w_glyph);
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg.seg_mode  = r_seg_mode;
    assign cfg.row_count = r_row_count;
    assign cfg.w_glyph   = r_w_glyph;

    ste_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_char_code   (i_char_code),
        .i_end_of_text (i_end_of_text),
        .i_cfg         (cfg),
        .i_q_full      (q_full),
        .o_in_stall    (o_in_stall),
        .o_push        (q_push),
        .o_item        (q_item)
    );

    ste_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    ste_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_q_valid    (q_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_seg_byte   (o_seg_byte),
        .o_byte_valid (o_byte_valid),
        .o_status     (o_status),
        .o_row_now    (o_row_now),
        .o_run_end    (o_run_end)
    );

    // an error or reject result never carries a byte
    a_status_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> !o_byte_valid)
        else $error("error result carries a driver byte");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue overflow");

    // the back only retires an item that is present
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue underflow");

endmodule
`default_nettype wire
